// ===== hdl/wsd_pkg.sv =====
// Shared types, result codes and opcodes for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

    // Result kinds carried on the output tuser
    localparam logic [1:0] K_MSG   = 2'd0;
    localparam logic [1:0] K_EMPTY = 2'd1;
    localparam logic [1:0] K_PONG  = 2'd2;
    localparam logic [1:0] K_CLOSE = 2'd3;

    // Frame opcodes the parser acts on
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [7:0] PONG_FIRST_BYTE = 8'h8A;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } wsd_result_t;

    // One queue entry: one result, or two for the pong header
    typedef struct packed {
        logic        two;
        wsd_result_t first;
        wsd_result_t second;
    } wsd_entry_t;

    typedef struct packed {
        logic       valid;
        wsd_entry_t entry;
    } wsd_slot_t;

endpackage
`default_nettype wire

// ===== hdl/wsd_front.sv =====
// Header parser and payload unmasker: turns received bytes into queued results.
`default_nettype none
module wsd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [7:0]        rx_byte,
    output wsd_pkg::wsd_slot_t     push
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [63:0] remain_reg, remain_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  mpos_reg, mpos_next;
    logic        closed_reg, closed_next;

    logic        hdr_done;
    logic [63:0] hdr_len;
    logic        hdr_empty;
    logic        is_msg;
    logic        fin;
    logic [7:0]  plain;
    logic [6:0]  len7;

    assign is_msg = opcode_reg inside {wsd_pkg::OP_TEXT, wsd_pkg::OP_CONT};
    assign len7   = rx_byte[6:0];
    assign plain  = rx_byte ^ key_reg[{mpos_reg, 3'b000} +: 8];

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        remain_next = remain_reg;
        hcnt_next   = hcnt_reg;
        key_next    = key_reg;
        mpos_next   = mpos_reg;
        closed_next = closed_reg;
        push        = '0;
        hdr_done    = 1'b0;
        hdr_len     = remain_reg;
        fin         = 1'b0;

        if (in_fire && !closed_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    key_next    = '0;
                    hcnt_next   = '0;
                    remain_next = '0;
                    if (len7 == wsd_pkg::LEN7_EXT16)
                        phase_next = PH_EXT16;
                    else if (len7 == wsd_pkg::LEN7_EXT64)
                        phase_next = PH_EXT64;
                    else
                    begin
                        remain_next = {57'd0, len7};
                        hdr_len     = {57'd0, len7};
                        if (rx_byte[7])
                            phase_next = PH_MASK;
                        else
                            hdr_done = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    remain_next = {remain_reg[55:0], rx_byte};
                    hdr_len     = remain_next;
                    hcnt_next   = hcnt_reg + 3'd1;
                    if ((phase_reg == PH_EXT16) ? (hcnt_reg == 3'd1) : (hcnt_reg == 3'd7))
                    begin
                        hcnt_next = '0;
                        if (masked_reg)
                            phase_next = PH_MASK;
                        else
                            hdr_done = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    key_next  = key_reg | ({24'd0, rx_byte} << {hcnt_reg[1:0], 3'b000});
                    hcnt_next = hcnt_reg + 3'd1;
                    if (hcnt_reg == 3'd3)
                        hdr_done = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    mpos_next   = mpos_reg + 2'd1;
                    remain_next = remain_reg - 64'd1;
                    fin         = (remain_next == 64'd0);
                    if (is_msg)
                    begin
                        push.valid       = 1'b1;
                        push.entry.first = '{wsd_pkg::K_MSG, plain, fin};
                    end
                    else if (opcode_reg == wsd_pkg::OP_PING)
                    begin
                        push.valid       = 1'b1;
                        push.entry.first = '{wsd_pkg::K_PONG, plain, fin};
                    end
                    else if (opcode_reg == wsd_pkg::OP_CLOSE && fin)
                    begin
                        push.valid       = 1'b1;
                        push.entry.first = '{wsd_pkg::K_CLOSE, 8'd0, 1'b0};
                        closed_next      = 1'b1;
                    end
                    if (fin)
                        phase_next = PH_HDR0;
                end
                default:
                    phase_next = PH_HDR0;
            endcase
        end

        // length and key known: announce the frame and pick the next phase
        hdr_empty = (hdr_len == 64'd0);
        if (hdr_done)
        begin
            mpos_next = '0;
            hcnt_next = '0;
            if (is_msg)
            begin
                if (hdr_empty)
                begin
                    push.valid       = 1'b1;
                    push.entry.first = '{wsd_pkg::K_EMPTY, 8'd0, 1'b1};
                end
            end
            else if (opcode_reg == wsd_pkg::OP_PING)
            begin
                push.valid        = 1'b1;
                push.entry.two    = 1'b1;
                push.entry.first  = '{wsd_pkg::K_PONG, wsd_pkg::PONG_FIRST_BYTE, 1'b0};
                push.entry.second = '{wsd_pkg::K_PONG, hdr_len[7:0], hdr_empty};
            end
            else if (opcode_reg == wsd_pkg::OP_CLOSE && hdr_empty)
            begin
                push.valid       = 1'b1;
                push.entry.first = '{wsd_pkg::K_CLOSE, 8'd0, 1'b0};
                closed_next      = 1'b1;
            end
            phase_next = hdr_empty ? PH_HDR0 : PH_PAYLOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            remain_reg <= '0;
            hcnt_reg   <= '0;
            key_reg    <= '0;
            mpos_reg   <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            remain_reg <= remain_next;
            hcnt_reg   <= hcnt_next;
            key_reg    <= key_next;
            mpos_reg   <= mpos_next;
            closed_reg <= closed_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/wsd_queue.sv =====
// Short result queue between the parser and the output sequencer.
`default_nettype none
module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wsd_pkg::wsd_slot_t push,
    output logic                    full,
    output wsd_pkg::wsd_slot_t      head,
    input  wire logic               pop
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    wsd_pkg::wsd_entry_t entries_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);
    assign head    = {(count_reg != '0), entries_reg[rd_ptr_reg]};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IDX_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IDX_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push.entry;
    end

endmodule
`default_nettype wire

// ===== hdl/wsd_back.sv =====
// Output sequencer: unpacks queue entries into single results behind an output register.
`default_nettype none
module wsd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wsd_pkg::wsd_slot_t head,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    logic                 valid_reg, valid_next;
    logic                 sub_reg, sub_next;
    wsd_pkg::wsd_result_t res_reg;
    wsd_pkg::wsd_result_t sel;
    logic                 load;

    assign load = head.valid && (!valid_reg || m_tready);
    assign sel  = sub_reg ? head.entry.second : head.entry.first;
    // a two-result entry is popped only when its second half is taken
    assign pop  = load && (!head.entry.two || sub_reg);

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = head.entry.two && !sub_reg;
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= sel;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data_byte;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule
`default_nettype wire

// ===== hdl/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser, result queue and output sequencer.
//
//  channel | dir | signals                     | one request
//  --------+-----+-----------------------------+-------------------------------------------
//  s_      | in  | tvalid tready tdata[7:0]    | one received byte (rx_byte)
//  m_      | out | tvalid tready tdata[7:0]    | one result: data_byte in tdata, kind in
//          |     | tuser[1:0] tlast            | tuser, last in tlast
//
//  Cycles: one received byte a cycle while the result queue is not full. A byte's results
//  are queued at the edge that takes it and enter the output register once it is free.
//  A ping header gives two results, sent one after the other; the queue absorbs this.
//  Reset: rst_n async, clears parser state, queue pointers and the output valid.
//  Stalls: s_tready falls only while the result queue is full; with m_tready low the
//  parser keeps taking bytes until the queue fills.
`default_nettype none
module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] data_byte
    output logic [1:0]      m_tuser,   // [1:0] kind
    output logic            m_tlast
);

    wsd_pkg::wsd_slot_t push;
    wsd_pkg::wsd_slot_t head;
    logic               full;
    logic               pop;
    logic               in_fire;

    // a byte is only taken when its results are sure of a queue slot
    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    wsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .rx_byte (s_tdata),
        .push    (push)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    wsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== hdl/wsd_checker.sv =====
// Port-level checks for the WebSocket frame deframer, bound to the top level.
`default_nettype none
module wsd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output request changed while stalled");

    // nothing follows a delivered close event
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == wsd_pkg::K_CLOSE) |=> !m_tvalid)
        else $error("result after close event");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == wsd_pkg::K_EMPTY) |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty message marker malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == wsd_pkg::K_CLOSE) |-> !m_tlast && (m_tdata == 8'd0))
        else $error("close event malformed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
